[design/sliding_window_event_counter_assert.svh]
// Assertion macros shared by the counter RTL. Simulation builds get real
// concurrent assertions; synthesis builds see empty bodies.
`ifndef SLIDING_WINDOW_EVENT_COUNTER_ASSERT_SVH
`define SLIDING_WINDOW_EVENT_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside of reset.
`define SWEC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("swec assertion failed");

// Checked on every clock edge, reset cycles included.
`define SWEC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("swec assertion failed");

`else

`define SWEC_ASSERT(lbl, prop)
`define SWEC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[design/swec_pkg.sv]
package swec_pkg;

   localparam int NUM_SLOTS    = 8;
   localparam int IDX_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam int TICK_W       = 48;
   localparam int COUNT_W      = 32;
   localparam int TOTAL_W      = 56;
   localparam int BUCKET_W     = 48;
   localparam int SLOT_TICKS_W = 32;
   localparam int MODE_W       = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 32;

   localparam int DIV_STEPS    = TICK_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   typedef logic [IDX_W-1:0] slot_idx_type;

   // Slot count widened by one bit so a doubled residue can be compared to it.
   localparam logic [IDX_W:0] SLOT_LIMIT = (IDX_W + 1)'(NUM_SLOTS);

   localparam logic [MODE_W-1:0] MODE_SLIDING = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ECHO    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_TICKS  = 1'd1;

   localparam logic [SLOT_TICKS_W-1:0] SLOT_TICKS_RESET = 32'd1000000;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Next bucket index, wrapping at the slot count.
   function automatic slot_idx_type slot_inc(slot_idx_type idx);
      if (idx == slot_idx_type'(NUM_SLOTS - 1)) begin
         return '0;
      end
      return idx + slot_idx_type'(1);
   endfunction

endpackage

[design/swec_div.sv]
// Restoring divider, one quotient bit per cycle. Alongside the quotient it
// keeps the quotient modulo the slot count, built from the same bits.
module swec_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [swec_pkg::TICK_W-1:0]          dividend,
   input  logic [swec_pkg::SLOT_TICKS_W-1:0]    divisor,
   output logic [swec_pkg::TICK_W-1:0]          quotient,
   output swec_pkg::slot_idx_type               quot_mod,
   output swec_pkg::div_status_type             status
);

   logic [swec_pkg::TICK_W-1:0]        num_ff, num_in;
   logic [swec_pkg::SLOT_TICKS_W-1:0]  den_ff, den_in;
   logic [swec_pkg::SLOT_TICKS_W-1:0]  rem_ff, rem_in;
   swec_pkg::slot_idx_type             mod_ff, mod_in;
   logic [swec_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;

   logic [swec_pkg::SLOT_TICKS_W:0]    shifted;
   logic [swec_pkg::SLOT_TICKS_W:0]    diff;
   logic                               ge;
   logic [swec_pkg::IDX_W:0]           mod2;

   always_comb begin
      shifted = {rem_ff, num_ff[swec_pkg::TICK_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
      mod2    = {mod_ff, ge};

      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         mod_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[swec_pkg::SLOT_TICKS_W-1:0] : shifted[swec_pkg::SLOT_TICKS_W-1:0];
         num_in = {num_ff[swec_pkg::TICK_W-2:0], ge};
         if (mod2 >= swec_pkg::SLOT_LIMIT) begin
            mod_in = swec_pkg::slot_idx_type'(mod2 - swec_pkg::SLOT_LIMIT);
         end else begin
            mod_in = swec_pkg::slot_idx_type'(mod2);
         end
         cnt_in = cnt_ff + swec_pkg::DIV_CNT_W'(1);
         if (cnt_ff == swec_pkg::DIV_CNT_W'(swec_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      mod_ff <= mod_in;
   end

   assign quotient    = num_ff;
   assign quot_mod    = mod_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[design/sliding_window_event_counter.sv]
// Channel   Direction  Signals
// req       in         req_valid, req_ready, req_now_ticks, req_event_count
// rsp       out        rsp_valid, rsp_ready, rsp_window_total
// csr       in         csr_write, csr_index, csr_wdata
//
// In sliding mode a word passes through the 48-step bit-serial divider, a check
// step, a sweep that clears P stale slots (P below NUM_SLOTS) and the final
// update step, after which the next word can be taken while the result is offered.
// Running-sum and echo modes go from acceptance straight to the final update step.
// One word is in flight at a time.
// Reset is synchronous and clears the buckets, the total and the last time.
// A result waiting on rsp_ready holds the block only at its final update step.
`include "sliding_window_event_counter_assert.svh"

module sliding_window_event_counter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [swec_pkg::TICK_W-1:0]           req_now_ticks,
   input  logic [swec_pkg::COUNT_W-1:0]          req_event_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [swec_pkg::TOTAL_W-1:0]          rsp_window_total,
   input  logic                                  csr_write,
   input  logic [swec_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [swec_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_ADD   = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [swec_pkg::MODE_W-1:0]         mode_ff, mode_in;
   logic [swec_pkg::SLOT_TICKS_W-1:0]   slot_ticks_ff, slot_ticks_in;
   logic [swec_pkg::TICK_W-1:0]         now_ff, now_in;
   logic [swec_pkg::COUNT_W-1:0]        cnt_ff, cnt_in;
   logic [swec_pkg::TOTAL_W-1:0]        total_ff, total_in;
   logic [swec_pkg::TICK_W-1:0]         last_ticks_ff, last_ticks_in;
   logic [swec_pkg::TICK_W-1:0]         last_slot_ff, last_slot_in;
   swec_pkg::slot_idx_type              last_idx_ff, last_idx_in;
   swec_pkg::slot_idx_type              idx_ff, idx_in;
   swec_pkg::slot_idx_type              left_ff, left_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [swec_pkg::TOTAL_W-1:0]        rsp_total_ff, rsp_total_in;

   logic [swec_pkg::BUCKET_W-1:0]       bucket_ff [swec_pkg::NUM_SLOTS];

   // Bucket write controls.
   logic                                bkt_we;
   logic [swec_pkg::BUCKET_W-1:0]       bkt_wd;
   logic                                clr_all;

   // Slot-number divider.
   logic                                div_start;
   logic [swec_pkg::SLOT_TICKS_W-1:0]   div_den;
   logic [swec_pkg::TICK_W-1:0]         div_quot;
   swec_pkg::slot_idx_type              div_mod;
   swec_pkg::div_status_type            div_status;

   // Datapath signals.
   swec_pkg::slot_idx_type              rd_idx;
   logic [swec_pkg::BUCKET_W-1:0]       bkt_rd;
   logic [swec_pkg::TOTAL_W-1:0]        bkt_rd_ext;
   logic [swec_pkg::BUCKET_W:0]         bkt_sum;
   logic [swec_pkg::BUCKET_W-1:0]       bkt_sat;
   logic [swec_pkg::TOTAL_W:0]          total_sum;
   logic [swec_pkg::TOTAL_W-1:0]        total_sat;
   logic [swec_pkg::TICK_W-1:0]         passed;
   logic                                backward;
   logic                                gap;

   // A slot length of zero behaves as one tick.
   assign div_den = (slot_ticks_ff == '0) ? swec_pkg::SLOT_TICKS_W'(1) : slot_ticks_ff;

   // The divider loads the timestamp at the same edge that takes the word.
   swec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (now_in),
      .divisor  (div_den),
      .quotient (div_quot),
      .quot_mod (div_mod),
      .status   (div_status)
   );

   // The bucket array has a single read index: the sweep pointer while stale
   // slots are cleared, and the slot of the current word otherwise.
   assign rd_idx     = (state_ff == ST_SWEEP) ? idx_ff : div_mod;
   assign bkt_rd     = bucket_ff[rd_idx];
   assign bkt_rd_ext = swec_pkg::TOTAL_W'(bkt_rd);

   // Saturating adds of the event count into the bucket and the total.
   assign bkt_sum   = {1'b0, bkt_rd} + (swec_pkg::BUCKET_W + 1)'(cnt_ff);
   assign bkt_sat   = bkt_sum[swec_pkg::BUCKET_W] ? '1 : bkt_sum[swec_pkg::BUCKET_W-1:0];
   assign total_sum = {1'b0, total_ff} + (swec_pkg::TOTAL_W + 1)'(cnt_ff);
   assign total_sat = total_sum[swec_pkg::TOTAL_W] ? '1 : total_sum[swec_pkg::TOTAL_W-1:0];

   // Slots advanced since the last update, counted by slot number so that a
   // bucket is never reused while it still holds an older slot's events.
   assign passed   = div_quot - last_slot_ff;
   assign backward = (now_ff < last_ticks_ff);
   assign gap      = (passed >= swec_pkg::TICK_W'(swec_pkg::NUM_SLOTS));

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      slot_ticks_in = slot_ticks_ff;
      now_in        = now_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      last_ticks_in = last_ticks_ff;
      last_slot_in  = last_slot_ff;
      last_idx_in   = last_idx_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_total_in  = rsp_total_ff;
      div_start     = 1'b0;
      bkt_we        = 1'b0;
      bkt_wd        = '0;
      clr_all       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_now_ticks;
               cnt_in = req_event_count;
               if (mode_ff == swec_pkg::MODE_SLIDING) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Time running backward or a gap of a whole window empties every
            // bucket; otherwise the stale slots are walked one per cycle.
            if (backward || gap) begin
               clr_all  = 1'b1;
               total_in = '0;
               left_in  = '0;
            end else begin
               left_in = passed[swec_pkg::IDX_W-1:0];
            end
            idx_in   = swec_pkg::slot_inc(last_idx_ff);
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (left_ff == '0) begin
               state_in = ST_ADD;
            end else begin
               total_in = (total_ff >= bkt_rd_ext) ? total_ff - bkt_rd_ext : '0;
               bkt_we   = 1'b1;
               bkt_wd   = '0;
               idx_in   = swec_pkg::slot_inc(idx_ff);
               left_in  = left_ff - swec_pkg::slot_idx_type'(1);
            end
         end
         ST_ADD: begin
            // The state update and the result word are committed together, and
            // only once the output register is free to take the word.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               unique case (mode_ff)
                  swec_pkg::MODE_SLIDING: begin
                     bkt_we        = 1'b1;
                     bkt_wd        = bkt_sat;
                     total_in      = total_sat;
                     rsp_total_in  = total_sat;
                     last_ticks_in = now_ff;
                     last_slot_in  = div_quot;
                     last_idx_in   = div_mod;
                  end
                  swec_pkg::MODE_RUNNING: begin
                     total_in     = total_sat;
                     rsp_total_in = total_sat;
                  end
                  swec_pkg::MODE_ECHO: begin
                     rsp_total_in = swec_pkg::TOTAL_W'(cnt_ff);
                  end
                  default: begin
                     // The unused mode code echoes the count like echo mode.
                     rsp_total_in = swec_pkg::TOTAL_W'(cnt_ff);
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Any register write empties the store.
      if (csr_write) begin
         unique case (csr_index)
            swec_pkg::CSR_WINDOW_MODE: mode_in = csr_wdata[swec_pkg::MODE_W-1:0];
            swec_pkg::CSR_SLOT_TICKS:  slot_ticks_in = csr_wdata[swec_pkg::SLOT_TICKS_W-1:0];
            default: begin
            end
         endcase
         clr_all       = 1'b1;
         total_in      = '0;
         last_ticks_in = '0;
         last_slot_in  = '0;
         last_idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= swec_pkg::MODE_SLIDING;
         slot_ticks_ff <= swec_pkg::SLOT_TICKS_RESET;
         total_ff      <= '0;
         last_ticks_ff <= '0;
         last_slot_ff  <= '0;
         last_idx_ff   <= '0;
         left_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         slot_ticks_ff <= slot_ticks_in;
         total_ff      <= total_in;
         last_ticks_ff <= last_ticks_in;
         last_slot_ff  <= last_slot_in;
         last_idx_ff   <= last_idx_in;
         left_ff       <= left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      now_ff       <= now_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         for (int i = 0; i < swec_pkg::NUM_SLOTS; i++) begin
            bucket_ff[i] <= '0;
         end
      end else if (bkt_we) begin
         bucket_ff[rd_idx] <= bkt_wd;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_total = rsp_total_ff;

   // The divider only runs while the sequencer waits on it.
   `SWEC_ASSERT(a_div_only_in_div, (div_status.busy |-> (state_ff == ST_DIV)))
   // A new result word comes only from the final update step.
   `SWEC_ASSERT(a_rsp_from_add, ($rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ADD)))
   // The sweep pointer stays inside the bucket array.
   `SWEC_ASSERT(a_sweep_idx_range,
      ((state_ff == ST_SWEEP) |-> (idx_ff <= swec_pkg::slot_idx_type'(swec_pkg::NUM_SLOTS - 1))))
   // Leaving the update step always lands in idle with a result on offer.
   `SWEC_ASSERT(a_add_exit,
      (((state_ff == ST_ADD) && (state_in != ST_ADD)) |=> (rsp_valid_ff && req_ready)))

endmodule

[verif/window_total_checker.sv]
module window_total_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [swec_pkg::TICK_W-1:0]           req_now_ticks,
   input  logic [swec_pkg::COUNT_W-1:0]          req_event_count,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [swec_pkg::TOTAL_W-1:0]          rsp_window_total,
   input  logic                                  csr_write,
   input  logic [swec_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [swec_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                    mismatch_count,
   output int                                    totals_pending
);
   import swec_pkg::*;

   localparam logic [63:0] BUCKET_MAX = (64'd1 << BUCKET_W) - 64'd1;
   localparam logic [63:0] TOTAL_MAX  = (64'd1 << TOTAL_W) - 64'd1;

   logic [MODE_W-1:0]       mode_q;
   logic [SLOT_TICKS_W-1:0] slot_len_q;
   logic [63:0]             bucket_sum [NUM_SLOTS];
   logic [63:0]             window_sum;
   logic [63:0]             last_tick;
   logic [TOTAL_W-1:0]      expected_totals [$];

   function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] ceiling);
      logic [63:0] s;
      s = a + b;
      return (s > ceiling) ? ceiling : s;
   endfunction

   function automatic void clear_window();
      int i;
      for (i = 0; i < NUM_SLOTS; i++) begin
         bucket_sum[i] = '0;
      end
      window_sum = '0;
      last_tick  = '0;
   endfunction

   // Updates the window state for one accepted word and returns the total it yields.
   function automatic logic [TOTAL_W-1:0] predict_total(logic [TICK_W-1:0] now,
                                                        logic [COUNT_W-1:0] amount);
      logic [63:0] span;
      logic [63:0] now_slot;
      logic [63:0] last_slot;
      logic [63:0] stale;
      logic [63:0] slot;
      int i;
      if (mode_q == MODE_RUNNING) begin
         window_sum = clip_add(window_sum, 64'(amount), TOTAL_MAX);
         return window_sum[TOTAL_W-1:0];
      end
      // The reserved mode echoes just like the echo mode.
      if (mode_q != MODE_SLIDING) begin
         return TOTAL_W'(amount);
      end
      span      = (slot_len_q == '0) ? 64'd1 : 64'(slot_len_q);
      now_slot  = 64'(now) / span;
      last_slot = last_tick / span;
      if (64'(now) < last_tick || now_slot - last_slot >= NUM_SLOTS) begin
         clear_window();
      end else begin
         stale = now_slot - last_slot;
         for (i = 1; i <= stale; i++) begin
            slot = (last_slot + i) % NUM_SLOTS;
            window_sum = (window_sum >= bucket_sum[slot]) ?
                         window_sum - bucket_sum[slot] : 64'd0;
            bucket_sum[slot] = '0;
         end
      end
      last_tick = 64'(now);
      slot = now_slot % NUM_SLOTS;
      bucket_sum[slot] = clip_add(bucket_sum[slot], 64'(amount), BUCKET_MAX);
      window_sum = clip_add(window_sum, 64'(amount), TOTAL_MAX);
      return window_sum[TOTAL_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      logic [TOTAL_W-1:0] want;
      if (reset) begin
         mode_q     = MODE_SLIDING;
         slot_len_q = SLOT_TICKS_RESET;
         clear_window();
         expected_totals.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_WINDOW_MODE) begin
               mode_q = csr_wdata[MODE_W-1:0];
            end else if (csr_index == CSR_SLOT_TICKS) begin
               slot_len_q = csr_wdata[SLOT_TICKS_W-1:0];
            end
            clear_window();
         end
         if (req_valid && req_ready) begin
            expected_totals.push_back(predict_total(req_now_ticks, req_event_count));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_totals.size() == 0) begin
               report_mismatch($sformatf("result word %0h with none outstanding",
                                         rsp_window_total));
            end else begin
               want = expected_totals.pop_front();
               if (rsp_window_total !== want) begin
                  report_mismatch($sformatf("window_total %0h, expected %0h",
                                            rsp_window_total, want));
               end
            end
         end
      end
      totals_pending = expected_totals.size();
   end

endmodule

[verif/tb_top.sv]
module tb_top;
   import swec_pkg::*;

   // The mode field is two bits wide; its last code is not a defined mode and
   // must behave like the echo mode.
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   // The final wait covers the slowest sliding-mode word.
   localparam int SETTLE_CYCLES = 70;
   // Cycles left after draining, before a register write, so the block is idle.
   localparam int IDLE_CYCLES   = 4;
   localparam int RANDOM_WORDS  = 1430;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [TICK_W-1:0]       req_now_ticks;
   logic [COUNT_W-1:0]      req_event_count;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [TOTAL_W-1:0]      rsp_window_total;
   logic                    csr_write;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   int                      mismatch_count;
   int                      totals_pending;

   // Stimulus-side copies of the settings, used only to shape the timestamps.
   logic [MODE_W-1:0]       cur_mode;
   logic [SLOT_TICKS_W-1:0] cur_slot_len;
   logic [TICK_W-1:0]       cursor;
   // When set, neither side inserts any idle cycles.
   bit                      steady;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sliding_window_event_counter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_ticks    (req_now_ticks),
      .req_event_count  (req_event_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_total (rsp_window_total),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   window_total_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_ticks    (req_now_ticks),
      .req_event_count  (req_event_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_total (rsp_window_total),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .totals_pending   (totals_pending)
   );

   // Idle length for either side: mostly none or a few cycles, now and then a
   // long stretch. In steady phases there is no idling at all.
   function automatic int pick_gap();
      int roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 50);
   endfunction

   // Next timestamp. Most steps stay within one slot or cross a few, some cross
   // four to seven slots, still short of the window length, and the rest are long
   // gaps, steps back in time or completely random times.
   function automatic logic [TICK_W-1:0] next_stamp();
      logic [63:0] span;
      logic [63:0] step;
      int roll;
      span = (cur_slot_len == '0) ? 64'd1 : 64'(cur_slot_len);
      roll = $urandom_range(0, 99);
      step = '0;
      if (roll < 10) begin
         step = '0;
      end else if (roll < 45) begin
         step = 64'($urandom_range(0, 32'(span - 64'd1)));
      end else if (roll < 80) begin
         step = span * $urandom_range(1, 3) + 64'($urandom_range(0, 32'(span - 64'd1)));
      end else if (roll < 88) begin
         step = span * $urandom_range(4, 7);
      end else if (roll < 93) begin
         step = span * $urandom_range(8, 12);
      end else if (roll < 97) begin
         cursor = cursor - TICK_W'($urandom_range(1, 32'(span)));
      end else begin
         cursor = TICK_W'({$urandom(), $urandom()});
      end
      cursor = cursor + TICK_W'(step);
      return cursor;
   endfunction

   function automatic logic [COUNT_W-1:0] next_amount();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return $urandom_range(0, 15);
      end
      if (roll < 80) begin
         return $urandom_range(0, 65535);
      end
      if (roll < 93) begin
         return $urandom();
      end
      return '1;
   endfunction

   // Offers one word and returns at the falling edge after it was taken.
   // Entered and left on a falling edge.
   task automatic send_word(input logic [TICK_W-1:0] stamp,
                            input logic [COUNT_W-1:0] amount);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_now_ticks   <= stamp;
      req_event_count <= amount;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Holds off the sender until every outstanding result has come back, then
   // leaves the block a few cycles to settle into idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (totals_pending != 0) begin
         @(negedge clock);
      end
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   // One register write; the extra edge keeps back-to-back writes from
   // lowering and raising the write enable in the same step.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Mode writes carry random upper bits, which the block must ignore.
   task automatic set_mode(input logic [MODE_W-1:0] mode);
      logic [CSR_DATA_W-1:0] value;
      value = $urandom();
      value[MODE_W-1:0] = mode;
      cur_mode = mode;
      write_reg(CSR_WINDOW_MODE, value);
   endtask

   task automatic set_slot_len(input logic [SLOT_TICKS_W-1:0] len);
      cur_slot_len = len;
      write_reg(CSR_SLOT_TICKS, CSR_DATA_W'(len));
   endtask

   // Random phase setup: mostly the sliding window, with a spread of slot
   // lengths from a single tick up to the largest value, and zero as well.
   task automatic configure_phase();
      logic [MODE_W-1:0]       mode;
      logic [SLOT_TICKS_W-1:0] len;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         mode = MODE_SLIDING;
      end else if (roll < 80) begin
         mode = MODE_RUNNING;
      end else if (roll < 92) begin
         mode = MODE_ECHO;
      end else begin
         mode = MODE_RESERVED;
      end
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         len = $urandom_range(1, 8);
      end else if (roll < 45) begin
         len = $urandom_range(9, 1000);
      end else if (roll < 55) begin
         len = '0;
      end else if (roll < 65) begin
         len = '1;
      end else if (roll < 75) begin
         len = SLOT_TICKS_RESET;
      end else begin
         len = $urandom();
      end
      // Either register may go first, and the slot length is sometimes kept.
      if ($urandom_range(0, 1) == 0) begin
         set_mode(mode);
         if ($urandom_range(0, 3) != 0) begin
            set_slot_len(len);
         end
      end else begin
         if ($urandom_range(0, 3) != 0) begin
            set_slot_len(len);
         end
         set_mode(mode);
      end
      if ($urandom_range(0, 4) == 0) begin
         cursor = '0;
      end
   endtask

   // The receiver stalls on its own schedule, independent of the sender.
   initial begin
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   // Main stimulus.
   initial begin
      int sent;
      int phase_len;
      int k;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_now_ticks   = '0;
      req_event_count = '0;
      csr_write       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      cur_mode        = MODE_SLIDING;
      cur_slot_len    = SLOT_TICKS_RESET;
      cursor          = '0;
      steady          = 1'b0;
      sent            = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, starting from the reset settings: sliding window with
      // one-million-tick slots.
      send_word('0, '0);
      send_word('0, '1);                 // largest count at the same tick
      send_word(48'd999_999, '1);        // last tick of the same slot
      send_word(48'd1_000_000, 32'd5);   // next slot
      send_word(48'd4_000_123, 32'd7);   // three stale slots cleared
      send_word(48'd11_000_000, 32'd1);  // seven slots on: still inside the window
      send_word(48'd19_000_000, 32'd2);  // eight slots on: everything is cleared
      send_word(48'd18_999_999, 32'd3);  // time runs backward
      send_word('1, '1);                 // latest possible time
      send_word('1, '1);

      // A zero slot length acts as a single tick.
      drain();
      set_slot_len('0);
      send_word(48'd5, 32'd1);
      send_word(48'd6, 32'd1);
      send_word(48'd13, 32'd1);
      send_word(48'd14, 32'd1);

      // Largest slot length, with times whose slot number crosses high bits.
      drain();
      set_slot_len('1);
      send_word('1, 32'd9);
      send_word(48'h0000_FFFF_FFFE, 32'd4);

      drain();
      set_mode(MODE_RUNNING);
      send_word(48'd3, '1);
      send_word('0, '1);
      send_word('1, '0);

      drain();
      set_mode(MODE_ECHO);
      send_word('0, '1);
      send_word('1, '0);

      drain();
      set_mode(MODE_RESERVED);
      send_word(48'h8000_0000_0001, '1);

      // Random part: phases of well-formed time sequences under changing
      // settings, each phase begun from an idle block.
      while (sent < RANDOM_WORDS) begin
         drain();
         steady = ($urandom_range(0, 3) == 0);
         configure_phase();
         phase_len = $urandom_range(20, 90);
         for (k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
            // Occasionally the sender holds off until all results are back.
            if ($urandom_range(0, 199) == 0) begin
               drain();
            end
            send_word(next_stamp(), next_amount());
            sent++;
         end
      end

      steady = 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS sliding_window_event_counter");
      end else begin
         $display("FAIL sliding_window_event_counter");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #2_400_000;
      $display("FAIL sliding_window_event_counter");
      $finish;
   end

endmodule
